[sv/gnhm_pkg.sv]
// Package for the greedy nearest-hit matcher: request and status codes,
// field widths and the structs passed between the cells and the control.
`timescale 1ns / 1ps
package gnhm_pkg;

    localparam int SENSOR_W = 7;
    localparam int POS_W    = 24;
    localparam int RES_W    = 25;
    localparam int SQ_W     = 2 * RES_W;
    localparam int DIST_W   = SQ_W + 1;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_MATCH = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_UNPAIRED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Broadcast from control to every cell
    typedef struct packed {
        logic                       load;
        logic                       shift;
        logic [SENSOR_W-1:0]        q_sensor;
        logic signed [POS_W-1:0]    q_x;
        logic signed [POS_W-1:0]    q_y;
    } gnhm_cmd_t;

    // Best candidate handed down the chain
    typedef struct packed {
        logic                       found;
        logic [DIST_W-1:0]          sqdist;
        logic signed [RES_W-1:0]    dx;
        logic signed [RES_W-1:0]    dy;
    } gnhm_tok_t;

endpackage

[sv/gnhm_req_if.sv]
// Request channel: valid/ready handshake with one hit request word.
// Depends on gnhm_pkg.
`timescale 1ns / 1ps
interface gnhm_req_if import gnhm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [SENSOR_W-1:0]     sensor;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, req_type, sensor, pos_x, pos_y, input ready);
    modport sink   (input valid, req_type, sensor, pos_x, pos_y, output ready);
endinterface

[sv/gnhm_res_if.sv]
// Result channel: valid/ready handshake with one status/residual word.
// Depends on gnhm_pkg.
`timescale 1ns / 1ps
interface gnhm_res_if import gnhm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [RES_W-1:0] residual_x;
    logic signed [RES_W-1:0] residual_y;

    modport source (output valid, status, residual_x, residual_y, input ready);
    modport sink   (input valid, status, residual_x, residual_y, output ready);
endinterface

[sv/gnhm_cell.sv]
// One table slot: holds a reference hit, computes its squared distance to
// the query and updates the best-candidate token passed along the chain.
// Depends on gnhm_pkg.
`timescale 1ns / 1ps
module gnhm_cell
    import gnhm_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gnhm_cmd_t               cmd,
    input  logic [CNT_W-1:0]        count,
    input  logic [IDX_W-1:0]        best_idx,
    input  logic [SENSOR_W-1:0]     nxt_sensor,
    input  logic signed [POS_W-1:0] nxt_x,
    input  logic signed [POS_W-1:0] nxt_y,
    output logic [SENSOR_W-1:0]     own_sensor,
    output logic signed [POS_W-1:0] own_x,
    output logic signed [POS_W-1:0] own_y,
    input  gnhm_tok_t               tok_in,
    input  logic [IDX_W-1:0]        idx_in,
    output gnhm_tok_t               tok_out,
    output logic [IDX_W-1:0]        idx_out
);

    localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] NXT_CNT = CNT_W'(CELL_IDX + 1);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);

    logic [SENSOR_W-1:0]     sensor_reg;
    logic signed [POS_W-1:0] x_reg, y_reg;
    logic signed [RES_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [DIST_W-1:0]       dist_reg;
    gnhm_tok_t               tok_reg, tok_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    live, eligible;

    // Entry storage: append at the fill point, close gaps on removal
    always_ff @(posedge clk)
    begin
        if (cmd.load && count == MY_CNT)
        begin
            sensor_reg <= cmd.q_sensor;
            x_reg      <= cmd.q_x;
            y_reg      <= cmd.q_y;
        end
        else if (cmd.shift && MY_IDX >= best_idx && NXT_CNT < count)
        begin
            sensor_reg <= nxt_sensor;
            x_reg      <= nxt_x;
            y_reg      <= nxt_y;
        end
    end

    // Distance pipeline: difference, squares, sum
    always_ff @(posedge clk)
    begin
        dx_reg   <= RES_W'(cmd.q_x) - RES_W'(x_reg);
        dy_reg   <= RES_W'(cmd.q_y) - RES_W'(y_reg);
        sqx_reg  <= SQ_W'(dx_reg * dx_reg);
        sqy_reg  <= SQ_W'(dy_reg * dy_reg);
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    end

    // Token update: strict less keeps the earliest entry on a tie
    assign live     = MY_CNT < count;
    assign eligible = live && sensor_reg == cmd.q_sensor;

    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (eligible && (!tok_in.found || dist_reg < tok_in.sqdist))
        begin
            tok_next.found  = 1'b1;
            tok_next.sqdist = dist_reg;
            tok_next.dx     = dx_reg;
            tok_next.dy     = dy_reg;
            idx_next        = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            idx_reg <= idx_next;
        end
    end

    assign own_sensor = sensor_reg;
    assign own_x      = x_reg;
    assign own_y      = y_reg;
    assign tok_out    = tok_reg;
    assign idx_out    = idx_reg;

endmodule

[sv/greedy_nearest_hit_matcher_core.sv]
// Greedy nearest-hit matcher. Clear and load requests pass from the execute
// state to the hold state and the output register; a match scans first, the best-
// candidate token walking the chain of cells one slot per cycle after a
// three-stage distance pipeline in each slot. One request is worked at a
// time; a finished result waits in the output register while the next
// request is taken. Depends on gnhm_pkg, gnhm_req_if, gnhm_res_if, gnhm_cell.
`timescale 1ns / 1ps
module greedy_nearest_hit_matcher_core
    import gnhm_pkg::*;
#(
    parameter int MAX_HITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    gnhm_req_if.sink    req,
    gnhm_res_if.source  res
);

    localparam int IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W = $clog2(MAX_HITS + 1);
    localparam int SCAN_LEN = MAX_HITS + 4;
    localparam int TMR_W = $clog2(SCAN_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_HITS);
    localparam logic [TMR_W-1:0] TMR_END  = TMR_W'(SCAN_LEN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TMR_W-1:0]        tmr_reg, tmr_next;
    logic [1:0]              qtype_reg;
    logic [SENSOR_W-1:0]     qsensor_reg;
    logic signed [POS_W-1:0] qx_reg, qy_reg;
    logic [1:0]              rstat_reg, rstat_next;
    logic signed [RES_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic                    ovalid_reg, ovalid_next;
    logic [1:0]              ostat_reg;
    logic signed [RES_W-1:0] ox_reg, oy_reg;
    gnhm_cmd_t               cmd;

    gnhm_tok_t               tok   [MAX_HITS+1];
    logic [IDX_W-1:0]        tidx  [MAX_HITS+1];
    logic [SENSOR_W-1:0]     c_sen [MAX_HITS+1];
    logic signed [POS_W-1:0] c_x   [MAX_HITS+1];
    logic signed [POS_W-1:0] c_y   [MAX_HITS+1];

    logic req_acc, out_free;
    assign req.ready = state_reg == S_IDLE;
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !ovalid_reg || res.ready;

    // Chain head: no candidate yet
    assign tok[0]  = '0;
    assign tidx[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HITS; gi++)
        begin : g_cell
            gnhm_cell #(
                .IDX_W    (IDX_W),
                .CNT_W    (CNT_W),
                .CELL_IDX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .count      (count_reg),
                .best_idx   (tidx[MAX_HITS]),
                .nxt_sensor (c_sen[gi+1]),
                .nxt_x      (c_x[gi+1]),
                .nxt_y      (c_y[gi+1]),
                .own_sensor (c_sen[gi]),
                .own_x      (c_x[gi]),
                .own_y      (c_y[gi]),
                .tok_in     (tok[gi]),
                .idx_in     (tidx[gi]),
                .tok_out    (tok[gi+1]),
                .idx_out    (tidx[gi+1])
            );
        end
    endgenerate

    // Last slot has no neighbor behind it
    assign c_sen[MAX_HITS] = c_sen[MAX_HITS-1];
    assign c_x[MAX_HITS]   = c_x[MAX_HITS-1];
    assign c_y[MAX_HITS]   = c_y[MAX_HITS-1];

    // Control sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tmr_next    = tmr_reg;
        rstat_next  = rstat_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        ovalid_next = ovalid_reg && !res.ready;
        cmd.load     = 1'b0;
        cmd.shift    = 1'b0;
        cmd.q_sensor = qsensor_reg;
        cmd.q_x      = qx_reg;
        cmd.q_y      = qy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                rstat_next = ST_DONE;
                rx_next    = '0;
                ry_next    = '0;
                tmr_next   = '0;
                state_next = S_HOLD;
                unique case (qtype_reg)
                    REQ_CLEAR: count_next = '0;
                    REQ_LOAD:
                    begin
                        if (count_reg == FULL_CNT)
                            rstat_next = ST_FULL;
                        else
                        begin
                            cmd.load   = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_MATCH: state_next = S_SCAN;
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                tmr_next = tmr_reg + 1'b1;
                if (tmr_reg == TMR_END)
                begin
                    state_next = S_HOLD;
                    if (tok[MAX_HITS].found)
                    begin
                        cmd.shift  = 1'b1;
                        count_next = count_reg - 1'b1;
                        rx_next    = tok[MAX_HITS].dx;
                        ry_next    = tok[MAX_HITS].dy;
                    end
                    else
                        rstat_next = ST_UNPAIRED;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            tmr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            tmr_reg    <= tmr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Request capture, pending result and output word
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            qtype_reg   <= req.req_type;
            qsensor_reg <= req.sensor;
            qx_reg      <= req.pos_x;
            qy_reg      <= req.pos_y;
        end
        rstat_reg <= rstat_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        if (state_reg == S_HOLD && out_free)
        begin
            ostat_reg <= rstat_reg;
            ox_reg    <= rx_reg;
            oy_reg    <= ry_reg;
        end
    end

    assign res.valid      = ovalid_reg;
    assign res.status     = ostat_reg;
    assign res.residual_x = ox_reg;
    assign res.residual_y = oy_reg;

endmodule
